### rtl/core/sine_tone_envelope_generator_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sine tone envelope generator
// Shared property forms used by the core's submodules.
// ----------------------------------------------------------------------------
`ifndef SINE_TONE_ENVELOPE_GENERATOR_CORE_ASSERT_SVH
`define SINE_TONE_ENVELOPE_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STEG_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define STEG_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/steg_pkg.sv
// ----------------------------------------------------------------------------
// steg_pkg
// Widths, register codes, reset values and shared types of the tone core.
// ----------------------------------------------------------------------------
`default_nettype none

package steg_pkg;

    // Field and register widths.
    localparam int PHASE_W     = 32;
    localparam int TONE_W      = 24;
    localparam int AMP_W       = 16;
    localparam int SAMPLE_W    = 16;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PHASE_STEP  = 2'd0,
        CFG_TONE_FRAMES = 2'd1,
        CFG_AMPLITUDE   = 2'd2
    } cfg_reg_t;

    // Register values after reset.
    localparam logic [PHASE_W-1:0] PHASE_STEP_RST  = 32'd85479040;
    localparam logic [TONE_W-1:0]  TONE_FRAMES_RST = 24'd22050;
    localparam logic [AMP_W-1:0]   AMPLITUDE_RST   = 16'd16384;

    // Saturation limits of the signed sample and the Q1.15 gain shift.
    localparam int SAMPLE_MAX       = 32767;
    localparam int SAMPLE_NEG_LIMIT = 32768;
    localparam int Q15_SHIFT        = 15;

    // Entries of the job queue between front and back end.
    localparam int JOB_QUEUE_DEPTH = 2;

    // Occupancy flags of the job queue.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

### rtl/core/steg_queue.sv
// ----------------------------------------------------------------------------
// steg_queue
// Small register FIFO that carries sample jobs from the front to the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sine_tone_envelope_generator_core_assert.svh"

module steg_queue
    import steg_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rd_data,
    output queue_status_t         status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Flags and head of the queue.
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign rd_data      = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage of the entries.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // The front end must hold off while full, the back end while empty.
    `STEG_ASSERT_IMP(a_queue_no_overflow, clk, rst_n, push, !status.full, "job pushed into a full queue")
    `STEG_ASSERT_IMP(a_queue_no_underflow, clk, rst_n, pop, !status.empty, "job popped from an empty queue")

endmodule

`default_nettype wire

### rtl/core/steg_front.sv
// ----------------------------------------------------------------------------
// steg_front
// Takes tick requests, keeps the tone position and phase, and queues one
// job for every tick that produces a sample.
// ----------------------------------------------------------------------------
`default_nettype none

module steg_front
    import steg_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int RAMP_FRAMES      = 110,
    parameter int FRAME_BITS       = 24,
    localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH),
    localparam int RAMP_W = $clog2(RAMP_FRAMES + 1),
    localparam int JOB_W  = ADDR_W + 2 * RAMP_W + 1
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               restart,
    input  wire logic [PHASE_W-1:0] phase_step,
    input  wire logic [TONE_W-1:0]  tone_frames,
    input  wire queue_status_t      q_status,
    output logic                    push,
    output logic      [JOB_W-1:0]   job
);

    localparam int CW     = (FRAME_BITS > RAMP_W) ? FRAME_BITS : RAMP_W;
    localparam int PROD_W = PHASE_W + ADDR_W + 1;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [RAMP_W-1:0] env_num;
        logic [RAMP_W-1:0] env_den;
        logic              last;
    } job_t;

    logic [FRAME_BITS+TONE_W-1:0] frames_wide;
    logic [FRAME_BITS-1:0]        frames;
    logic [FRAME_BITS-1:0]        half_frames;
    logic [FRAME_BITS-1:0]        idx_eff;
    logic [FRAME_BITS-1:0]        remaining;
    logic [FRAME_BITS-1:0]        idx_reg, idx_next;
    logic [PHASE_W-1:0]           phase_eff;
    logic [PHASE_W-1:0]           phase_reg, phase_next;
    logic [PROD_W-1:0]            phase_prod;
    logic [RAMP_W-1:0]            ramp_calc;
    logic [RAMP_W-1:0]            ramp_eff;
    logic [RAMP_W-1:0]            ramp_reg, ramp_next;
    logic                         active_eff;
    logic                         active_reg, active_next;
    logic                         accept;
    logic                         produce;
    logic                         is_last;
    job_t                         job_d;

    // Requests are held off only while the job queue is full.
    assign in_stall = q_status.full;
    assign accept   = in_valid && !q_status.full;

    // Tone length seen at the counter width; upper bits are dropped.
    assign frames_wide = {{FRAME_BITS{1'b0}}, tone_frames};
    assign frames      = frames_wide[FRAME_BITS-1:0];
    assign half_frames = frames >> 1;
    assign ramp_calc   = (CW'(half_frames) > CW'(RAMP_FRAMES)) ?
                         RAMP_W'(RAMP_FRAMES) : RAMP_W'(half_frames);

    // A restart request resets the tone before the sample of the same tick.
    assign idx_eff    = restart ? '0 : idx_reg;
    assign phase_eff  = restart ? '0 : phase_reg;
    assign ramp_eff   = restart ? ramp_calc : ramp_reg;
    assign active_eff = restart ? (frames != '0) : active_reg;

    assign produce   = active_eff && (idx_eff < frames);
    assign remaining = frames - idx_eff;
    assign is_last   = (remaining == FRAME_BITS'(1));

    // Sine table address is the phase scaled by the table depth.
    assign phase_prod = PROD_W'(phase_eff) * PROD_W'(SINE_TABLE_DEPTH);

    // Envelope fraction: rising, falling or flat.
    always_comb
    begin
        job_d.addr = phase_prod[PHASE_W +: ADDR_W];
        job_d.last = is_last;
        priority if ((ramp_eff != '0) && (CW'(idx_eff) < CW'(ramp_eff)))
        begin
            job_d.env_num = RAMP_W'(idx_eff);
            job_d.env_den = ramp_eff;
        end
        else if ((ramp_eff != '0) && (CW'(remaining) <= CW'(ramp_eff)))
        begin
            job_d.env_num = RAMP_W'(remaining);
            job_d.env_den = ramp_eff;
        end
        else
        begin
            job_d.env_num = RAMP_W'(1);
            job_d.env_den = RAMP_W'(1);
        end
    end

    assign push = accept && produce;
    assign job  = job_d;

    // Tone state after the request.
    always_comb
    begin
        idx_next    = idx_reg;
        phase_next  = phase_reg;
        ramp_next   = ramp_reg;
        active_next = active_reg;
        if (accept)
        begin
            ramp_next   = ramp_eff;
            idx_next    = produce ? idx_eff + FRAME_BITS'(1) : idx_eff;
            phase_next  = produce ? phase_eff + phase_step : phase_eff;
            active_next = produce && !is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            phase_reg  <= '0;
            ramp_reg   <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            idx_reg    <= idx_next;
            phase_reg  <= phase_next;
            ramp_reg   <= ramp_next;
            active_reg <= active_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/steg_back.sv
// ----------------------------------------------------------------------------
// steg_back
// Turns queued jobs into samples: sine lookup, gain and envelope products,
// a serial divide by the ramp length, saturation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sine_tone_envelope_generator_core_assert.svh"

module steg_back
    import steg_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int RAMP_FRAMES      = 110,
    localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH),
    localparam int RAMP_W = $clog2(RAMP_FRAMES + 1),
    localparam int JOB_W  = ADDR_W + 2 * RAMP_W + 1
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire queue_status_t              q_status,
    input  wire logic       [JOB_W-1:0]     job,
    output logic                            pop,
    input  wire logic       [AMP_W-1:0]     amplitude,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic signed     [SAMPLE_W-1:0]  sample,
    output logic                            last
);

    localparam int MAG_W  = SAMPLE_W - 1;
    localparam int PROD_W = MAG_W + AMP_W;
    localparam int ENV_W  = PROD_W + RAMP_W;
    localparam int DIV_W  = ENV_W - Q15_SHIFT;
    localparam int CNT_W  = $clog2(DIV_W);

    localparam longint unsigned DEPTH_L     = SINE_TABLE_DEPTH;
    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [RAMP_W-1:0] env_num;
        logic [RAMP_W-1:0] env_den;
        logic              last;
    } job_t;

    typedef logic signed [SAMPLE_W-1:0] rom_t [SINE_TABLE_DEPTH];

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_MUL_AMP = 5'b00010,
        S_MUL_ENV = 5'b00100,
        S_DIV     = 5'b01000,
        S_DONE    = 5'b10000
    } back_state_t;

    // Sine table: quarter-wave fold, Q30 Taylor series to x^11, rounded to Q15.
    function automatic rom_t build_sine();
        rom_t                        rom;
        longint unsigned             q;
        longint unsigned             x;
        longint unsigned             x2;
        longint unsigned             t;
        longint unsigned             s;
        longint unsigned             v;
        logic                        neg;
        logic signed [SAMPLE_W-1:0]  mag;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++)
        begin
            q   = 64'd4 * longint'(i);
            neg = 1'b0;
            if (q >= 64'd2 * DEPTH_L)
            begin
                q   = q - 64'd2 * DEPTH_L;
                neg = 1'b1;
            end
            if (q > DEPTH_L)
            begin
                q = 64'd2 * DEPTH_L - q;
            end
            x  = (HALF_PI_Q30 * q) / DEPTH_L;
            x2 = (x * x) >> 30;
            t  = Q30_ONE - (x2 / 64'd110);
            t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
            t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
            t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
            t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
            s  = (x * t) >> 30;
            v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
            if (v > 64'd32767)
            begin
                v = 64'd32767;
            end
            mag    = SAMPLE_W'(v);
            rom[i] = neg ? -mag : mag;
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_sine();

    back_state_t                state_reg, state_next;
    job_t                       job_q;
    logic signed [SAMPLE_W-1:0] rom_reg, rom_next;
    logic [RAMP_W-1:0]          num_reg, num_next;
    logic [RAMP_W-1:0]          den_reg, den_next;
    logic                       job_last_reg, job_last_next;
    logic [MAG_W-1:0]           mag;
    logic [PROD_W-1:0]          prod_reg, prod_next;
    logic                       neg_reg, neg_next;
    logic [ENV_W-1:0]           env_prod;
    logic [DIV_W-1:0]           quo_reg, quo_next;
    logic [RAMP_W-1:0]          rem_reg, rem_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [RAMP_W:0]            trial;
    logic [RAMP_W:0]            trial_diff;
    logic                       trial_ge;
    logic                       slot_free;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic                       last_reg, last_next;
    logic signed [SAMPLE_W-1:0] sat_value;

    assign job_q = job_t'(job);

    // Magnitude of the table value and the envelope product.
    assign mag      = rom_reg[SAMPLE_W-1] ? MAG_W'(-rom_reg) : rom_reg[MAG_W-1:0];
    assign env_prod = ENV_W'(prod_reg) * ENV_W'(num_reg);

    // One restoring division step per cycle.
    assign trial      = {rem_reg, quo_reg[DIV_W-1]};
    assign trial_ge   = (trial >= {1'b0, den_reg});
    assign trial_diff = trial - {1'b0, den_reg};

    // Saturation of the quotient to the signed sample range.
    always_comb
    begin
        if (neg_reg)
        begin
            sat_value = (quo_reg > DIV_W'(SAMPLE_NEG_LIMIT)) ?
                        SAMPLE_W'(SAMPLE_NEG_LIMIT) : -SAMPLE_W'(quo_reg);
        end
        else
        begin
            sat_value = (quo_reg > DIV_W'(SAMPLE_MAX)) ?
                        SAMPLE_W'(SAMPLE_MAX) : SAMPLE_W'(quo_reg);
        end
    end

    // The output register may be reloaded when empty or being taken.
    assign slot_free = !out_valid_reg || !out_stall;
    assign pop       = (state_reg == S_IDLE) && !q_status.empty;

    // Sequencer of one sample job.
    always_comb
    begin
        state_next     = state_reg;
        rom_next       = rom_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        job_last_next  = job_last_reg;
        prod_next      = prod_reg;
        neg_next       = neg_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        sample_next    = sample_reg;
        last_next      = last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_status.empty)
                begin
                    rom_next      = SINE_ROM[job_q.addr];
                    num_next      = job_q.env_num;
                    den_next      = job_q.env_den;
                    job_last_next = job_q.last;
                    state_next    = S_MUL_AMP;
                end
            end
            S_MUL_AMP:
            begin
                prod_next  = PROD_W'(mag) * PROD_W'(amplitude);
                neg_next   = rom_reg[SAMPLE_W-1];
                state_next = S_MUL_ENV;
            end
            S_MUL_ENV:
            begin
                quo_next   = env_prod[Q15_SHIFT +: DIV_W];
                rem_next   = '0;
                cnt_next   = CNT_W'(DIV_W - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next = trial_ge ? trial_diff[RAMP_W-1:0] : trial[RAMP_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], trial_ge};
                if (cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    sample_next    = sat_value;
                    last_next      = job_last_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rom_reg      <= rom_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        job_last_reg <= job_last_next;
        prod_reg     <= prod_next;
        neg_reg      <= neg_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        sample_reg   <= sample_next;
        last_reg     <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign last      = last_reg;

    // Divider invariants and holding of a finished sample behind a full output.
    `STEG_ASSERT_IMP(a_div_den_nonzero, clk, rst_n, state_reg == S_DIV, den_reg != '0, "envelope divisor is zero")
    `STEG_ASSERT_IMP(a_div_rem_below_den, clk, rst_n, state_reg == S_DIV, rem_reg < den_reg, "partial remainder not below divisor")
    `STEG_ASSERT_NXT(a_done_waits_slot, clk, rst_n, (state_reg == S_DONE) && out_valid_reg && out_stall, state_reg == S_DONE, "finished sample left before the output slot was free")

endmodule

`default_nettype wire

### rtl/core/sine_tone_envelope_generator_core.sv
// ----------------------------------------------------------------------------
// sine_tone_envelope_generator_core
// DDS sine tone generator with linear attack and release envelope.
// ----------------------------------------------------------------------------
// Each input request is one sample tick; restart high begins a new tone at
// sample zero. A tick during a tone yields one signed 16-bit sample, with
// last set on the final sample, and ticks outside a tone yield nothing. The
// back end applies the envelope fraction with a restoring divider, one
// quotient bit per cycle, and takes a new job only once the last is done;
// the front end keeps taking ticks until the two-entry job queue fills.
// The sine table is a constant ROM, so no fill pass follows reset.
// Configuration must be written only while the core is idle; the core
// itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module sine_tone_envelope_generator_core
    import steg_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int RAMP_FRAMES      = 110,
    parameter int FRAME_BITS       = 24
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_write_en,
    input  wire logic [CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic                      restart,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic signed [SAMPLE_W-1:0]     sample,
    output logic                           last
);

    localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH);
    localparam int RAMP_W = $clog2(RAMP_FRAMES + 1);
    localparam int JOB_W  = ADDR_W + 2 * RAMP_W + 1;

    logic [PHASE_W-1:0] phase_step_reg, phase_step_next;
    logic [TONE_W-1:0]  tone_frames_reg, tone_frames_next;
    logic [AMP_W-1:0]   amplitude_reg, amplitude_next;
    queue_status_t      q_status;
    logic               push;
    logic               pop;
    logic [JOB_W-1:0]   job_in;
    logic [JOB_W-1:0]   job_out;

    // Configuration register writes.
    always_comb
    begin
        phase_step_next  = phase_step_reg;
        tone_frames_next = tone_frames_reg;
        amplitude_next   = amplitude_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_PHASE_STEP:  phase_step_next  = cfg_wdata[PHASE_W-1:0];
                CFG_TONE_FRAMES: tone_frames_next = cfg_wdata[TONE_W-1:0];
                CFG_AMPLITUDE:   amplitude_next   = cfg_wdata[AMP_W-1:0];
                default:
                begin
                    phase_step_next = phase_step_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg  <= PHASE_STEP_RST;
            tone_frames_reg <= TONE_FRAMES_RST;
            amplitude_reg   <= AMPLITUDE_RST;
        end
        else
        begin
            phase_step_reg  <= phase_step_next;
            tone_frames_reg <= tone_frames_next;
            amplitude_reg   <= amplitude_next;
        end
    end

    // Front end: tone position, phase and envelope selection.
    steg_front #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .RAMP_FRAMES      (RAMP_FRAMES),
        .FRAME_BITS       (FRAME_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .restart     (restart),
        .phase_step  (phase_step_reg),
        .tone_frames (tone_frames_reg),
        .q_status    (q_status),
        .push        (push),
        .job         (job_in)
    );

    // Job queue between the two halves.
    steg_queue #(
        .WIDTH (JOB_W),
        .DEPTH (JOB_QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (job_in),
        .pop     (pop),
        .rd_data (job_out),
        .status  (q_status)
    );

    // Back end: arithmetic and output register.
    steg_back #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .RAMP_FRAMES      (RAMP_FRAMES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .job       (job_out),
        .pop       (pop),
        .amplitude (amplitude_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample    (sample),
        .last      (last)
    );

endmodule

`default_nettype wire
